// ----- src/esc_pkg.sv -----
package esc_pkg;

    // Field widths
    localparam int UNIX_W  = 31;
    localparam int TZ_W    = 17;
    localparam int T_W     = 32;    // clamped adjusted time, below 2^32
    localparam int ADJ_W   = 33;    // signed adjusted time
    localparam int DAYS_W  = 16;    // whole days, below 49711
    localparam int SOD_W   = 17;    // seconds of day
    localparam int CYC_W   = 6;     // 4-year cycles since 1970
    localparam int CDAY_W  = 11;    // day within a 4-year cycle
    localparam int WKX_W   = 17;    // days + 3 ahead of the weekday modulo
    localparam int WKQ_W   = 13;
    localparam int REMH_W  = 12;    // seconds within the hour
    localparam int YEAR_W  = 11;
    localparam int DOY_W   = 9;
    localparam int MONTH_W = 4;
    localparam int DOM_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int WDAY_W  = 3;

    // Calendar constants
    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [10:0] DAYS_PER_CYC  = 11'd1461;
    localparam logic [10:0] DAYS_YEAR1    = 11'd365;
    localparam logic [10:0] DAYS_YEAR2    = 11'd730;
    localparam logic [10:0] DAYS_YEAR3    = 11'd1096;
    localparam logic [YEAR_W-1:0] BASE_YEAR = 11'd1970;
    localparam logic [ADJ_W-1:0]  DST_SECS  = 33'd3600;
    localparam logic [2:0]  WDAY_OFFSET   = 3'd3;   // 1970-01-01 was a Thursday

    // Reciprocal multipliers: q = (x * M) >> S is exact for x below 2^N
    // when M = ceil(2^S / d) and S = N + ceil(log2 d).
    // Days: t >> 7 divided by 675 (86400 = 128 * 675), N = 25
    localparam int DAY_PRE = 7;
    localparam int DAY_S   = 35;
    localparam logic [25:0] DAY_M = 26'(((64'd1 << DAY_S) + 64'd674) / 64'd675);
    // 4-year cycles: days / 1461, N = 16
    localparam int CYC_S   = 27;
    localparam logic [16:0] CYC_M = 17'(((64'd1 << CYC_S) + 64'd1460) / 64'd1461);
    // Weekday: (days + 3) / 7, N = 17
    localparam int WK_S    = 20;
    localparam logic [17:0] WK_M  = 18'(((64'd1 << WK_S) + 64'd6) / 64'd7);
    // Hour: seconds of day / 3600, N = 17
    localparam int HR_S    = 29;
    localparam logic [17:0] HR_M  = 18'(((64'd1 << HR_S) + 64'd3599) / 64'd3600);
    // Minute: seconds of hour / 60, N = 12
    localparam int MN_S    = 18;
    localparam logic [12:0] MN_M  = 13'(((64'd1 << MN_S) + 64'd59) / 64'd60);

    // Register map index (paddr[2])
    localparam logic REG_TZ  = 1'b0;
    localparam logic REG_DST = 1'b1;

    typedef struct packed {
        logic [TZ_W-1:0] tz_west;   // two's complement seconds west of UTC
        logic            dst;
    } esc_cfg_t;

endpackage

// ----- src/esc_datapath.sv -----
module esc_datapath
    import esc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [UNIX_W-1:0]    unix_seconds,
    input  esc_cfg_t             cfg,
    output logic                 out_valid,
    output logic [YEAR_W-1:0]    year,
    output logic [DOY_W-1:0]     day_of_year,
    output logic [MONTH_W-1:0]   month,
    output logic [DOM_W-1:0]     day_of_month,
    output logic [HOUR_W-1:0]    hour,
    output logic [MIN_W-1:0]     minute,
    output logic [SEC_W-1:0]     second,
    output logic [WDAY_W-1:0]    weekday,
    output logic                 clamped
);

    // Valid chain, one bit per stage
    logic [6:0] vld_reg;

    // Stage 1: adjusted, clamped time
    logic [ADJ_W-1:0]   adj;
    logic [T_W-1:0]     s1_t_next, s1_t_reg;
    logic               s1_clamp_reg;

    // Stage 2: whole days
    logic [50:0]        day_prod;
    logic [DAYS_W-1:0]  s2_days_next, s2_days_reg;
    logic [T_W-1:0]     s2_t_reg;
    logic               s2_clamp_reg;

    // Stage 3: seconds of day
    logic [ADJ_W-1:0]   day_secs;
    logic [SOD_W-1:0]   s3_sod_next, s3_sod_reg;
    logic [DAYS_W-1:0]  s3_days_reg;
    logic               s3_clamp_reg;

    // Stage 4: quotients for cycle, weekday and hour
    logic [32:0]        cyc_prod;
    logic [WKX_W-1:0]   wk_x;
    logic [34:0]        wk_prod;
    logic [34:0]        hr_prod;
    logic [CYC_W-1:0]   s4_cyc_next, s4_cyc_reg;
    logic [WKQ_W-1:0]   s4_wkq_next, s4_wkq_reg;
    logic [HOUR_W-1:0]  s4_hour_next, s4_hour_reg;
    logic [DAYS_W-1:0]  s4_days_reg;
    logic [SOD_W-1:0]   s4_sod_reg;
    logic               s4_clamp_reg;

    // Stage 5: remainders
    logic [CDAY_W-1:0]  s5_cday_next, s5_cday_reg;
    logic [WDAY_W-1:0]  s5_wday_next, s5_wday_reg;
    logic [REMH_W-1:0]  s5_remh_next, s5_remh_reg;
    logic [CYC_W-1:0]   s5_cyc_reg;
    logic [HOUR_W-1:0]  s5_hour_reg;
    logic               s5_clamp_reg;

    // Stage 6: year, day of year, minute
    logic [1:0]         yoff;
    logic [24:0]        mn_prod;
    logic [YEAR_W-1:0]  s6_year_next, s6_year_reg;
    logic [DOY_W-1:0]   s6_doy_next, s6_doy_reg;
    logic               s6_leap_next, s6_leap_reg;
    logic [MIN_W-1:0]   s6_min_next, s6_min_reg;
    logic [REMH_W-1:0]  s6_remh_reg;
    logic [WDAY_W-1:0]  s6_wday_reg;
    logic [HOUR_W-1:0]  s6_hour_reg;
    logic               s6_clamp_reg;

    // Stage 7: month, day of month, second
    logic [DOY_W-1:0]   feb_end;
    logic [DOY_W-1:0]   jul_end;
    logic [DOY_W-1:0]   r;
    logic [DOY_W-1:0]   rr;
    logic [1:0]         pair;
    logic               second_half;
    logic [MONTH_W-1:0] base_month;
    logic [MONTH_W-1:0] month_next;
    logic [DOM_W-1:0]   dom_next;
    logic [REMH_W-1:0]  min_secs;
    logic [SEC_W-1:0]   sec_next;

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[5:0], in_valid};
        end
    end

    assign out_valid = vld_reg[6];

    // Offset and daylight saving at 33 bits; negative means clamp
    always_comb
    begin
        adj = {2'b00, unix_seconds}
            - {{(ADJ_W - TZ_W){cfg.tz_west[TZ_W-1]}}, cfg.tz_west}
            + (cfg.dst ? DST_SECS : '0);
        s1_t_next = adj[ADJ_W-1] ? '0 : adj[T_W-1:0];
    end

    // Days and seconds of day
    always_comb
    begin
        day_prod     = 51'(s1_t_reg[T_W-1:DAY_PRE]) * 51'(DAY_M);
        s2_days_next = day_prod[DAY_S +: DAYS_W];
        day_secs     = 33'(s2_days_reg) * 33'(SECS_PER_DAY);
        s3_sod_next  = SOD_W'({1'b0, s2_t_reg} - day_secs);
    end

    // Cycle, weekday and hour quotients
    always_comb
    begin
        cyc_prod     = 33'(s3_days_reg) * 33'(CYC_M);
        s4_cyc_next  = cyc_prod[CYC_S +: CYC_W];
        wk_x         = WKX_W'(s3_days_reg) + WKX_W'(WDAY_OFFSET);
        wk_prod      = 35'(wk_x) * 35'(WK_M);
        s4_wkq_next  = wk_prod[WK_S +: WKQ_W];
        hr_prod      = 35'(s3_sod_reg) * 35'(HR_M);
        s4_hour_next = hr_prod[HR_S +: HOUR_W];
    end

    // Remainders
    always_comb
    begin
        s5_cday_next = CDAY_W'(s4_days_reg - DAYS_W'(s4_cyc_reg) * DAYS_W'(DAYS_PER_CYC));
        s5_wday_next = WDAY_W'(WKX_W'(s4_days_reg) + WKX_W'(WDAY_OFFSET)
                       - WKX_W'(s4_wkq_reg) * WKX_W'(3'd7));
        s5_remh_next = REMH_W'(s4_sod_reg - SOD_W'(s4_hour_reg) * SOD_W'(SECS_PER_HOUR));
    end

    // Year within the cycle; the third year is the leap year
    always_comb
    begin
        priority if (s5_cday_reg < DAYS_YEAR1)
        begin
            yoff        = 2'd0;
            s6_doy_next = DOY_W'(s5_cday_reg);
        end
        else if (s5_cday_reg < DAYS_YEAR2)
        begin
            yoff        = 2'd1;
            s6_doy_next = DOY_W'(s5_cday_reg - DAYS_YEAR1);
        end
        else if (s5_cday_reg < DAYS_YEAR3)
        begin
            yoff        = 2'd2;
            s6_doy_next = DOY_W'(s5_cday_reg - DAYS_YEAR2);
        end
        else
        begin
            yoff        = 2'd3;
            s6_doy_next = DOY_W'(s5_cday_reg - DAYS_YEAR3);
        end
        s6_year_next = BASE_YEAR + YEAR_W'({s5_cyc_reg, 2'b00}) + YEAR_W'(yoff);
        s6_leap_next = (yoff == 2'd2);
        mn_prod      = 25'(s5_remh_reg) * 25'(MN_M);
        s6_min_next  = mn_prod[MN_S +: MIN_W];
    end

    // Month and day: January, February, then 61-day pairs from March and August
    always_comb
    begin
        feb_end = DOY_W'(59) + DOY_W'(s6_leap_reg);
        jul_end = DOY_W'(212) + DOY_W'(s6_leap_reg);
        r           = '0;
        rr          = '0;
        pair        = 2'd0;
        second_half = 1'b0;
        base_month  = '0;
        priority if (s6_doy_reg < DOY_W'(31))
        begin
            month_next = MONTH_W'(0);
            dom_next   = DOM_W'(s6_doy_reg + DOY_W'(1));
        end
        else if (s6_doy_reg < feb_end)
        begin
            month_next = MONTH_W'(1);
            dom_next   = DOM_W'(s6_doy_reg - DOY_W'(30));
        end
        else
        begin
            if (s6_doy_reg < jul_end)
            begin
                r          = s6_doy_reg - feb_end;
                base_month = MONTH_W'(2);
            end
            else
            begin
                r          = s6_doy_reg - jul_end;
                base_month = MONTH_W'(7);
            end
            priority if (r >= DOY_W'(122))
            begin
                pair = 2'd2;
                rr   = r - DOY_W'(122);
            end
            else if (r >= DOY_W'(61))
            begin
                pair = 2'd1;
                rr   = r - DOY_W'(61);
            end
            else
            begin
                pair = 2'd0;
                rr   = r;
            end
            second_half = (rr >= DOY_W'(31));
            month_next  = base_month + MONTH_W'({pair, 1'b0}) + MONTH_W'(second_half);
            dom_next    = DOM_W'(rr - (second_half ? DOY_W'(31) : '0) + DOY_W'(1));
        end
        min_secs = REMH_W'(s6_min_reg) * REMH_W'(SECS_PER_MIN);
        sec_next = SEC_W'(s6_remh_reg - min_secs);
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        s1_t_reg     <= s1_t_next;
        s1_clamp_reg <= adj[ADJ_W-1];

        s2_days_reg  <= s2_days_next;
        s2_t_reg     <= s1_t_reg;
        s2_clamp_reg <= s1_clamp_reg;

        s3_sod_reg   <= s3_sod_next;
        s3_days_reg  <= s2_days_reg;
        s3_clamp_reg <= s2_clamp_reg;

        s4_cyc_reg   <= s4_cyc_next;
        s4_wkq_reg   <= s4_wkq_next;
        s4_hour_reg  <= s4_hour_next;
        s4_days_reg  <= s3_days_reg;
        s4_sod_reg   <= s3_sod_reg;
        s4_clamp_reg <= s3_clamp_reg;

        s5_cday_reg  <= s5_cday_next;
        s5_wday_reg  <= s5_wday_next;
        s5_remh_reg  <= s5_remh_next;
        s5_cyc_reg   <= s4_cyc_reg;
        s5_hour_reg  <= s4_hour_reg;
        s5_clamp_reg <= s4_clamp_reg;

        s6_year_reg  <= s6_year_next;
        s6_doy_reg   <= s6_doy_next;
        s6_leap_reg  <= s6_leap_next;
        s6_min_reg   <= s6_min_next;
        s6_remh_reg  <= s5_remh_reg;
        s6_wday_reg  <= s5_wday_reg;
        s6_hour_reg  <= s5_hour_reg;
        s6_clamp_reg <= s5_clamp_reg;

        year         <= s6_year_reg;
        day_of_year  <= s6_doy_reg;
        month        <= month_next;
        day_of_month <= dom_next;
        hour         <= s6_hour_reg;
        minute       <= s6_min_reg;
        second       <= sec_next;
        weekday      <= s6_wday_reg;
        clamped      <= s6_clamp_reg;
    end

    // Checks
    a_fields_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (month <= MONTH_W'(11)) && (day_of_month != '0)
                      && (day_of_month <= DOM_W'(31)) && (weekday <= WDAY_W'(6)))
        else $error("calendar field out of range");

    a_time_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hour <= HOUR_W'(23)) && (minute <= MIN_W'(59))
                      && (second <= SEC_W'(59)))
        else $error("time of day out of range");

    a_february: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (month == MONTH_W'(1)) |-> (day_of_month <= DOM_W'(29)))
        else $error("February day beyond 29");

    a_clamp_epoch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clamped |-> (year == BASE_YEAR) && (day_of_year == '0)
                                 && (hour == '0) && (weekday == WDAY_OFFSET))
        else $error("clamped result is not the epoch");

endmodule

// ----- src/epoch_seconds_to_calendar_top.sv -----
// Unix seconds to calendar date and time of day.
// The result strobe done rises once the start timestamp has passed every register stage.
// Throughput: one timestamp per cycle; busy is always low, seven register stages
// carry the reciprocal multiplies and their remainders in flight.
// Reset (rst_n low, asynchronous) clears the stage valids, the offset and daylight saving.
// Results are shown for one cycle only; the receiver cannot stall them.
module epoch_seconds_to_calendar_top
    import esc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // Command
    input  logic                 start,
    output logic                 busy,
    input  logic [UNIX_W-1:0]    unix_seconds,
    // Result
    output logic                 done,
    output logic [YEAR_W-1:0]    year,
    output logic [DOY_W-1:0]     day_of_year,
    output logic [MONTH_W-1:0]   month,
    output logic [DOM_W-1:0]     day_of_month,
    output logic [HOUR_W-1:0]    hour,
    output logic [MIN_W-1:0]     minute,
    output logic [SEC_W-1:0]     second,
    output logic [WDAY_W-1:0]    weekday,
    output logic                 clamped
);

    logic [TZ_W-1:0] tz_reg;
    logic            dst_reg;
    logic            wr_en;
    esc_cfg_t        cfg;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign wr_en  = psel & penable & pwrite & pready;

    // Configuration registers, word index from paddr[2]
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tz_reg  <= '0;
            dst_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_TZ:  tz_reg  <= pwdata[TZ_W-1:0];
                REG_DST: dst_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (paddr[2])
            REG_TZ:  prdata = {{(32 - TZ_W){1'b0}}, tz_reg};
            REG_DST: prdata = {31'b0, dst_reg};
            default: prdata = '0;
        endcase
    end

    assign cfg.tz_west = tz_reg;
    assign cfg.dst     = dst_reg;

    esc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (start & ~busy),
        .unix_seconds (unix_seconds),
        .cfg          (cfg),
        .out_valid    (done),
        .year         (year),
        .day_of_year  (day_of_year),
        .month        (month),
        .day_of_month (day_of_month),
        .hour         (hour),
        .minute       (minute),
        .second       (second),
        .weekday      (weekday),
        .clamped      (clamped)
    );

endmodule
